FILE: rtl/core/aging_node_table_with_universe_lookup_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the aging node table
// Shared concurrent checks, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef AGING_NODE_TABLE_WITH_UNIVERSE_LOOKUP_ASSERT_SVH
`define AGING_NODE_TABLE_WITH_UNIVERSE_LOOKUP_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define ANTUL_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("antul: invariant violated");

// Trigger is followed by the consequence in the next cycle.
`define ANTUL_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("antul: sequence violated");

`endif

FILE: rtl/core/antul_pkg.sv
// ---------------------------------------------------------------------------
// antul_pkg
// Types and codes shared by the node table cells and the controller.
// ---------------------------------------------------------------------------
package antul_pkg;

  localparam int UNI_W   = 15;
  localparam int PORTS_W = 3;
  localparam int UNI_N   = 4;

  localparam logic [1:0] CMD_REPLY  = 2'd0;
  localparam logic [1:0] CMD_EXPIRE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_EXPIRED  = 3'd3;
  localparam logic [2:0] ST_HIT      = 3'd4;
  localparam logic [2:0] ST_MISS     = 3'd5;

  typedef struct packed {
    logic [31:0]                 addr;
    logic [PORTS_W-1:0]          ports;
    logic [UNI_N-1:0][UNI_W-1:0] uni;
    logic [31:0]                 seen;
  } entry_t;

  typedef struct packed {
    logic step;   // advance the chain by one cell
    logic drop;   // head leaves the table, chain shortens
    logic wr_en;  // direct write at the insert index
  } cell_ctrl_t;

endpackage

FILE: rtl/core/antul_if.sv
// ---------------------------------------------------------------------------
// antul channel interfaces
// Command and result channels with a valid/ready transfer.
// ---------------------------------------------------------------------------
interface antul_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] node_addr;
  logic [2:0]  active_ports;
  logic [14:0] universe_a;
  logic [14:0] universe_b;
  logic [14:0] universe_c;
  logic [14:0] universe_d;
  logic [31:0] now_ticks;
  logic [14:0] query_universe;

  modport source (output valid, cmd, node_addr, active_ports, universe_a, universe_b,
                  universe_c, universe_d, now_ticks, query_universe, input ready);
  modport sink (input valid, cmd, node_addr, active_ports, universe_a, universe_b,
                universe_c, universe_d, now_ticks, query_universe, output ready);
endinterface

interface antul_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_addr;
  logic [4:0]  entries_held;
  logic [3:0]  slot;

  modport source (output valid, status, found_addr, entries_held, slot, input ready);
  modport sink (input valid, status, found_addr, entries_held, slot, output ready);
endinterface

FILE: rtl/core/antul_cell.sv
// ---------------------------------------------------------------------------
// antul_cell
// One table position: takes its neighbour's entry on a step, or the feed.
// ---------------------------------------------------------------------------
module antul_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  antul_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]       len_m1,
  input  logic [IW-1:0]       wr_idx,
  input  antul_pkg::entry_t   nbr,
  input  antul_pkg::entry_t   feed,
  output antul_pkg::entry_t   ent
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && wr_idx == MY_IDX) begin
      ent <= feed;
    end else if (ctrl.step) begin
      if (MY_IDX < len_m1) begin
        ent <= nbr;
      end else if (!ctrl.drop && MY_IDX == len_m1) begin
        ent <= feed;
      end
    end
  end

endmodule

FILE: rtl/core/aging_node_table_with_universe_lookup.sv
// ---------------------------------------------------------------------------
// aging_node_table_with_universe_lookup
// Ordered node table held in a rotating chain of cells.
// ---------------------------------------------------------------------------
// The table lives in a row of MAX_NODES cells; cell 0 is the head. Each
// command walks the valid entries by rotating the occupied part of the row
// one cell per clock: the head is examined and fed back into the last
// occupied cell, or dropped on expiry so the row closes up in order. After
// the walk over the entry_count entries, a finishing state writes the
// result register once the output is free; an unknown command skips the
// walk. A new command is taken once the result is registered, while that
// result may still wait on the output.
// The result register holds the answer until its transfer. age_limit may
// be written only while no command is in flight.
// ---------------------------------------------------------------------------
`include "aging_node_table_with_universe_lookup_assert.svh"

module aging_node_table_with_universe_lookup #(
  parameter int MAX_NODES      = 16,
  parameter int PORTS_PER_NODE = 4
) (
  input  logic        clk,
  input  logic        rst,
  antul_req_if.sink   req,
  antul_rsp_if.source rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_NODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]  state;
  logic [31:0] age_limit;

  // captured command
  logic [1:0]          cmd_r;
  antul_pkg::entry_t   new_ent;
  logic [14:0]         query_r;

  // walk bookkeeping
  logic [CW-1:0] count;
  logic [CW-1:0] len;
  logic [CW-1:0] remain;
  logic [IW-1:0] k;
  logic          done;
  logic [IW-1:0] hit_slot;
  logic [31:0]   hit_addr;

  // result register
  logic        rsp_valid;
  logic [2:0]  rsp_status;
  logic [31:0] rsp_found;
  logic [4:0]  rsp_held;
  logic [3:0]  rsp_slot;

  antul_pkg::entry_t     ent [MAX_NODES];
  antul_pkg::entry_t     head;
  antul_pkg::entry_t     feed;
  antul_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]         len_m1;
  logic [IW-1:0]         wr_idx;

  logic [2:0]  ports_sat;
  logic        walking;
  logic        addr_match;
  logic        uni_hit;
  logic        keep;
  logic [31:0] age;
  logic        rsp_free;
  logic        accept;
  logic [IW+3:0] k_wide;
  logic [IW+3:0] cnt_slot_wide;
  logic [CW+4:0] held_wide;
  logic [CW-1:0] count_fin;

  assign head     = ent[0];
  assign rsp_free = !rsp_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign walking  = (state == S_WALK) && (remain != '0);

  assign ports_sat = (req.active_ports > 3'(PORTS_PER_NODE)) ?
                     3'(PORTS_PER_NODE) : req.active_ports;

  assign addr_match = !done && (head.addr == new_ent.addr);
  assign age        = new_ent.seen - head.seen;
  assign keep       = (age <= age_limit);

  always_comb begin
    uni_hit = 1'b0;
    for (int p = 0; p < antul_pkg::UNI_N; p++) begin
      if (p < PORTS_PER_NODE && 3'(p) < head.ports && head.uni[p] == query_r) begin
        uni_hit = 1'b1;
      end
    end
  end

  // chain control: rotate while walking, write directly on insert
  always_comb begin
    ctrl.step  = walking;
    ctrl.drop  = walking && (cmd_r == antul_pkg::CMD_EXPIRE) && !keep;
    ctrl.wr_en = (state == S_FIN) && rsp_free && (cmd_r == antul_pkg::CMD_REPLY) &&
                 !done && (count != FULL);
    feed       = head;
    if (state == S_FIN || (cmd_r == antul_pkg::CMD_REPLY && addr_match)) begin
      feed = new_ent;
    end
  end

  assign len_m1 = IW'(len - 1'b1);
  assign wr_idx = IW'(count);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_NODES; gi++) begin : g_cell
      antul_pkg::entry_t nbr;
      if (gi == MAX_NODES - 1) begin : g_last
        assign nbr = feed;
      end else begin : g_mid
        assign nbr = ent[gi+1];
      end
      antul_cell #(.IW(IW), .IDX(gi)) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .len_m1 (len_m1),
        .wr_idx (wr_idx),
        .nbr    (nbr),
        .feed   (feed),
        .ent    (ent[gi])
      );
    end
  endgenerate

  assign k_wide        = {4'b0, hit_slot};
  assign cnt_slot_wide = {4'b0, wr_idx};

  always_comb begin
    count_fin = count;
    if (cmd_r == antul_pkg::CMD_EXPIRE) begin
      count_fin = len;
    end else if (cmd_r == antul_pkg::CMD_REPLY && !done && count != FULL) begin
      count_fin = count + 1'b1;
    end
  end
  assign held_wide = {5'b0, count_fin};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= 32'd10000;
    end else if (cfg_we) begin
      age_limit <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // raise on a finished command, drop once the result transfers
      if (state == S_FIN && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (remain == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            count     <= count_fin;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // walk data path
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r          <= req.cmd;
      new_ent.addr   <= req.node_addr;
      new_ent.ports  <= ports_sat;
      new_ent.uni    <= {req.universe_d, req.universe_c, req.universe_b, req.universe_a};
      new_ent.seen   <= req.now_ticks;
      query_r        <= req.query_universe;
      len            <= count;
      k              <= '0;
      done           <= 1'b0;
      hit_slot       <= '0;
      hit_addr       <= '0;
      // unknown command: skip the walk
      remain <= (req.cmd == antul_pkg::CMD_REPLY || req.cmd == antul_pkg::CMD_EXPIRE ||
                 req.cmd == antul_pkg::CMD_LOOKUP) ? count : '0;
    end else if (walking) begin
      remain <= remain - 1'b1;
      k      <= k + 1'b1;
      if (ctrl.drop) begin
        len <= len - 1'b1;
      end
      if (cmd_r == antul_pkg::CMD_REPLY && addr_match) begin
        done     <= 1'b1;
        hit_slot <= k;
      end
      if (cmd_r == antul_pkg::CMD_LOOKUP && !done && uni_hit) begin
        done     <= 1'b1;
        hit_slot <= k;
        hit_addr <= head.addr;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_FIN && rsp_free) begin
      rsp_held <= held_wide[4:0];
      unique case (cmd_r)
        antul_pkg::CMD_REPLY: begin
          rsp_found <= '0;
          if (done) begin
            rsp_status <= antul_pkg::ST_UPDATED;
            rsp_slot   <= k_wide[3:0];
          end else if (count != FULL) begin
            rsp_status <= antul_pkg::ST_INSERTED;
            rsp_slot   <= cnt_slot_wide[3:0];
          end else begin
            rsp_status <= antul_pkg::ST_DROPPED;
            rsp_slot   <= '0;
          end
        end
        antul_pkg::CMD_EXPIRE: begin
          rsp_status <= antul_pkg::ST_EXPIRED;
          rsp_found  <= '0;
          rsp_slot   <= '0;
        end
        antul_pkg::CMD_LOOKUP: begin
          rsp_status <= done ? antul_pkg::ST_HIT : antul_pkg::ST_MISS;
          rsp_found  <= hit_addr;
          rsp_slot   <= k_wide[3:0];
        end
        default: begin
          rsp_status <= antul_pkg::ST_MISS;
          rsp_found  <= '0;
          rsp_slot   <= '0;
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.found_addr   = rsp_found;
  assign rsp.entries_held = rsp_held;
  assign rsp.slot         = rsp_slot;

  // checks
  `ANTUL_ALWAYS(a_count_bound, count <= FULL)
  `ANTUL_ALWAYS(a_len_bound, state == S_IDLE || len <= count)
  `ANTUL_NEXT(a_accept_starts, accept, state == S_WALK)
  `ANTUL_NEXT(a_fin_emits, state == S_FIN && rsp_free, rsp_valid && state == S_IDLE)

endmodule

FILE: bench/tb_aging_node_table_with_universe_lookup.sv
// ---------------------------------------------------------------------------
// Testbench for aging_node_table_with_universe_lookup
// Drives reply, expire, lookup and unknown commands through the request channel,
// predicts every result from a private copy of the node table and checks
// each field of each result transfer in order. A directed table comes first,
// then random traffic under three idling patterns and several age limits.
// ---------------------------------------------------------------------------
module tb_aging_node_table_with_universe_lookup;

  localparam int NODES     = 16;
  localparam int PORTS     = 4;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1450;

  // command code outside the defined set
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] node_addr;
    logic [2:0]  active_ports;
    logic [14:0] ua, ub, uc, ud;
    logic [31:0] now_ticks;
    logic [14:0] query;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_addr;
    logic [4:0]  entries_held;
    logic [3:0]  slot;
  } answer_t;

  // directed row: stimulus, plus a typed-in answer where obvious
  typedef struct packed {
    cmd_item_t item;
    logic      has_fixed;
    answer_t   fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  antul_req_if req ();
  antul_rsp_if rsp ();

  aging_node_table_with_universe_lookup #(
    .MAX_NODES(NODES), .PORTS_PER_NODE(PORTS)
  ) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow table
  logic [31:0]         limit_m;
  int                  count_m;
  antul_pkg::entry_t   tab_m [NODES];

  answer_t answers_due [$];
  int      fails = 0;
  int      sent = 0, got = 0, hits = 0, drops = 0;
  int      src_idle = 0, snk_idle = 0;
  int      wdog = 0;

  function automatic answer_t table_step(cmd_item_t it);
    answer_t           a;
    int                w;
    logic              hit;
    antul_pkg::entry_t e;
    a = '{status: antul_pkg::ST_MISS, found_addr: '0, entries_held: '0, slot: '0};
    e.addr  = it.node_addr;
    e.ports = (it.active_ports > PORTS) ? 3'(PORTS) : it.active_ports;
    e.uni   = {it.ud, it.uc, it.ub, it.ua};
    e.seen  = it.now_ticks;
    case (it.cmd)
      antul_pkg::CMD_REPLY: begin
        hit = 1'b0;
        for (int i = 0; i < count_m && !hit; i++) begin
          if (tab_m[i].addr == it.node_addr) begin
            tab_m[i] = e; a.status = antul_pkg::ST_UPDATED; a.slot = 4'(i); hit = 1'b1;
          end
        end
        if (!hit) begin
          if (count_m >= NODES) a.status = antul_pkg::ST_DROPPED;
          else begin
            tab_m[count_m] = e; a.slot = 4'(count_m);
            count_m++; a.status = antul_pkg::ST_INSERTED;
          end
        end
      end
      antul_pkg::CMD_EXPIRE: begin
        w = 0;
        for (int i = 0; i < count_m; i++) begin
          if (32'(it.now_ticks - tab_m[i].seen) <= limit_m) begin
            tab_m[w] = tab_m[i]; w++;
          end
        end
        count_m = w; a.status = antul_pkg::ST_EXPIRED;
      end
      antul_pkg::CMD_LOOKUP: begin
        hit = 1'b0;
        for (int i = 0; i < count_m && !hit; i++)
          for (int p = 0; p < tab_m[i].ports && p < PORTS && !hit; p++)
            if (tab_m[i].uni[p] == it.query) begin
              hit = 1'b1; a.found_addr = tab_m[i].addr; a.slot = 4'(i);
            end
        a.status = hit ? antul_pkg::ST_HIT : antul_pkg::ST_MISS;
      end
      default: ;
    endcase
    a.entries_held = 5'(count_m);
    return a;
  endfunction

  // Random item; addresses from a small pool so updates and full tables occur
  function automatic cmd_item_t rand_item(logic [31:0] base_now);
    cmd_item_t it;
    int r;
    r = $urandom_range(99);
    it.cmd = (r < 50) ? antul_pkg::CMD_REPLY : (r < 62) ? antul_pkg::CMD_EXPIRE :
             (r < 97) ? antul_pkg::CMD_LOOKUP : CMD_BAD;
    it.node_addr = ($urandom_range(3) == 0) ? $urandom() : 32'h0A000000 | $urandom_range(23);
    if ($urandom_range(15) == 0) it.node_addr = ~it.node_addr;
    it.active_ports = 3'($urandom_range(7));
    // narrow universe pool so lookups hit; occasional full-range values
    it.ua = ($urandom_range(4) == 0) ? 15'($urandom()) : 15'($urandom_range(11));
    it.ub = ($urandom_range(4) == 0) ? 15'($urandom()) : 15'($urandom_range(11));
    it.uc = ($urandom_range(4) == 0) ? 15'($urandom()) : 15'($urandom_range(11));
    it.ud = ($urandom_range(4) == 0) ? 15'($urandom()) : 15'($urandom_range(11));
    it.query = ($urandom_range(4) == 0) ? 15'($urandom()) : 15'($urandom_range(11));
    it.now_ticks = ($urandom_range(9) == 0) ? $urandom() : base_now + $urandom_range(20000);
    return it;
  endfunction

  // Result side: sample at the edge, randomise ready for the next cycle
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got++;
        if (answers_due.size() == 0) begin
          $error("result transfer with nothing expected"); fails++;
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp.status); fails++;
          end
          if (rsp.found_addr !== want.found_addr) begin
            $error("found_addr expected %h actual %h", want.found_addr, rsp.found_addr);
            fails++;
          end
          if (rsp.entries_held !== want.entries_held) begin
            $error("entries_held expected %0d actual %0d", want.entries_held,
                   rsp.entries_held); fails++;
          end
          if (rsp.slot !== want.slot) begin
            $error("slot expected %0d actual %0d", want.slot, rsp.slot); fails++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) wdog <= 0;
    else if (answers_due.size() != 0 || req.valid) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("watchdog expired");
        $display("status: fail");
        $finish;
      end
    end
  end

  // Hold the item until its transfer; valid stays up for the next item
  // unless the sender idles first
  task automatic send(cmd_item_t it, logic has_fixed, answer_t fixed);
    answer_t a;
    while ($urandom_range(99) < src_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    {req.cmd, req.node_addr, req.active_ports, req.universe_a, req.universe_b,
     req.universe_c, req.universe_d, req.now_ticks, req.query_universe} <= it;
    do @(posedge clk); while (!req.ready);
    a = table_step(it);
    if (has_fixed && a !== fixed) begin
      $error("directed row answer expected %h predicted %h", fixed, a); fails++;
    end
    answers_due.push_back(a);
    sent++;
    if (it.cmd == antul_pkg::CMD_LOOKUP && a.status == antul_pkg::ST_HIT) hits++;
    if (a.status == antul_pkg::ST_DROPPED) drops++;
  endtask

  // Wait until idle, let the walk finish, then write the age limit
  task automatic set_limit(logic [31:0] v);
    int n;
    n = 0;
    req.valid <= 1'b0;
    while (answers_due.size() != 0 && n < 100000) begin
      @(posedge clk); n++;
    end
    repeat (NODES + 4) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_m = v;
  endtask

  function automatic row_t mk(logic [1:0] c, logic [31:0] ad, logic [2:0] ap,
                              logic [14:0] u0, logic [14:0] u1, logic [14:0] u2,
                              logic [14:0] u3, logic [31:0] nw, logic [14:0] q,
                              logic fx, logic [2:0] st, logic [31:0] fa,
                              logic [4:0] eh, logic [3:0] sl);
    row_t r;
    r.item = '{c, ad, ap, u0, u1, u2, u3, nw, q};
    r.has_fixed = fx;
    r.fixed = '{st, fa, eh, sl};
    return r;
  endfunction

  initial begin
    row_t      rows [$];
    cmd_item_t it;
    logic [31:0] base;
    int limits_seen;
    req.valid = 1'b0;
    {req.cmd, req.node_addr, req.active_ports, req.universe_a, req.universe_b,
     req.universe_c, req.universe_d, req.now_ticks, req.query_universe} = '0;
    limit_m = 32'd10000;
    count_m = 0;
    foreach (tab_m[i]) tab_m[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: empty table, extremes, saturation, unused ports,
    // unknown command, full table, age wrap
    rows.push_back(mk(antul_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 15'h7FFF, 1,
                      antul_pkg::ST_MISS, 0, 0, 0));
    rows.push_back(mk(antul_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                      antul_pkg::ST_EXPIRED, 0, 0, 0));
    rows.push_back(mk(antul_pkg::CMD_REPLY, 32'hFFFFFFFF, 3'd7, 15'h7FFF, 1, 2, 3,
                      32'hFFFFFFFF, 0, 1, antul_pkg::ST_INSERTED, 0, 1, 0));
    rows.push_back(mk(antul_pkg::CMD_REPLY, 0, 1, 5, 15'h7FFF, 7, 8, 100, 0, 1,
                      antul_pkg::ST_INSERTED, 0, 2, 1));
    rows.push_back(mk(antul_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 15'h7FFF, 1,
                      antul_pkg::ST_HIT, 32'hFFFFFFFF, 2, 0));
    rows.push_back(mk(antul_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0, 0));
    rows.push_back(mk(antul_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 8, 1,
                      antul_pkg::ST_MISS, 0, 2, 0));
    rows.push_back(mk(CMD_BAD, 32'h12345678, 4, 1, 1, 1, 1, 5, 1, 1,
                      antul_pkg::ST_MISS, 0, 2, 0));
    rows.push_back(mk(antul_pkg::CMD_REPLY, 0, 0, 6, 6, 6, 6, 200, 0, 1,
                      antul_pkg::ST_UPDATED, 0, 2, 1));
    rows.push_back(mk(antul_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 6, 1,
                      antul_pkg::ST_MISS, 0, 2, 0));
    for (int i = 2; i < NODES; i++)
      rows.push_back(mk(antul_pkg::CMD_REPLY, 32'h0B000000 + i, 4, 15'(i), 0, 0,
                        15'(100 + i), 300, 0, 1, antul_pkg::ST_INSERTED, 0,
                        5'(i + 1), 4'(i)));
    rows.push_back(mk(antul_pkg::CMD_REPLY, 32'hC0A80001, 2, 0, 0, 0, 0, 400, 0, 1,
                      antul_pkg::ST_DROPPED, 0, 16, 0));
    rows.push_back(mk(antul_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 15'd115, 0, 0, 0, 0, 0));
    // at 1000 the entry stamped 0xFFFFFFFF has age 1001, others young
    rows.push_back(mk(antul_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 0, 0, 0));
    // stamps after now look very old: only the wrapped stamp (age 51) stays
    rows.push_back(mk(antul_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0, 50, 0, 1,
                      antul_pkg::ST_EXPIRED, 0, 1, 0));
    foreach (rows[i]) send(rows[i].item, rows[i].has_fixed, rows[i].fixed);

    // Random phases: idling pattern and age limit change between phases
    limits_seen = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_limit(32'd0);
        1: set_limit(32'hFFFFFFFF);
        2: set_limit(32'd10000);
        3: set_limit($urandom());
        4: set_limit(32'd3000);
        default: set_limit(32'd15000);
      endcase
      limits_seen++;
      if (ph < 2) begin src_idle = 30; snk_idle = 49; end
      else if (ph < 4) begin src_idle = 49; snk_idle = 30; end
      else begin src_idle = 0; snk_idle = 0; end
      base = $urandom();
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        it = rand_item(base);
        base = base + $urandom_range(500);
        send(it, 1'b0, '0);
      end
    end

    // Drain, then let any walk in flight finish
    req.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (NODES + 4) @(posedge clk);

    $display("covered %0d commands, %0d results, %0d lookup hits, %0d drops, %0d limits",
             sent, got, hits, drops, limits_seen);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
